// ===== rtl/mfds_pkg.sv =====
// ----------------------------------------------------------------------------
// mfds_pkg: shared types and constants of the fractional divider search
// Field widths, divider sizing, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package mfds_pkg;

  // Raw input and output field widths
  localparam int unsigned SRC_W        = 30;
  localparam int unsigned WANT_W       = 26;
  localparam int unsigned DIV_CODE_W   = 12;
  localparam int unsigned FRACT_CODE_W = 8;
  localparam int unsigned ERR_W        = 19;
  localparam int unsigned STATUS_W     = 2;

  // Scaled clocks (Hz / 100) and shared divider sizing
  localparam int unsigned SRC_SW      = 24;
  localparam int unsigned WANT_SW     = 20;
  localparam int unsigned LIMIT_SHIFT = 12;  // fraction limit uses want * 4096
  localparam int unsigned DVD_W       = 32;
  localparam int unsigned DVS_W       = 24;
  localparam int unsigned SCALE_DIV   = 100;

  // Scale by 100 as (x / 4) / 25, the divide by 25 as a reciprocal multiply;
  // exact for every x / 4 below 2^30
  localparam int unsigned SCALE_PRE     = 2;
  localparam int unsigned SCALE_SHIFT   = 33;
  localparam int unsigned SCALE_RECIP_W = 29;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 29'd343597384;  // ceil(2^33 / 25)

  // Defaults for the top-level parameters
  localparam int unsigned MAX_FRACTION_DEF = 256;
  localparam int unsigned DIVIDE_BITS_DEF  = 12;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEL_SRC,
    SEL_WANT,
    SEL_LIMIT,
    SEL_TRIAL
  } div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_SRC,
    ST_SCALE_WANT,
    ST_CHECK,
    ST_LIMIT,
    ST_TRIAL,
    ST_NEXT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic     load_in;
    logic     scale;
    logic     div_start;
    div_sel_e div_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic zero_clk;
    logic search_end;
    logic exact;
  } stat_t;

endpackage

// ===== rtl/mfds_div.sv =====
// ----------------------------------------------------------------------------
// mfds_div: serial restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module mfds_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mfds_pkg::DVD_W-1:0] dividend_i,
  input  logic [mfds_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [mfds_pkg::DVD_W-1:0] quo_o,
  output logic [mfds_pkg::DVS_W-1:0] rem_o
);
  import mfds_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   partial;
  logic [DVS_W:0]   diff;

  // Shift one dividend bit into the partial remainder, subtract on no borrow
  assign partial = {rem_q, quo_q[DVD_W-1]};
  assign diff    = partial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ~diff[DVS_W]};
      rem_d = diff[DVS_W] ? partial[DVS_W-1:0] : diff[DVS_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/mfds_dp.sv =====
// ----------------------------------------------------------------------------
// mfds_dp: datapath of the fractional divider search
// Holds operands, the trial fraction, the best pair so far and the result.
// ----------------------------------------------------------------------------
module mfds_dp #(
  parameter int unsigned MaxFraction = mfds_pkg::MAX_FRACTION_DEF,
  parameter int unsigned DivideBits  = mfds_pkg::DIVIDE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mfds_pkg::cmd_t                   cmd_i,
  output mfds_pkg::stat_t                  stat_o,
  input  logic [mfds_pkg::SRC_W-1:0]       src_hz_i,
  input  logic [mfds_pkg::WANT_W-1:0]      want_hz_i,
  output logic [mfds_pkg::DIV_CODE_W-1:0]  divide_code_o,
  output logic [mfds_pkg::FRACT_CODE_W-1:0] fract_code_o,
  output logic [mfds_pkg::ERR_W-1:0]       best_error_o,
  output logic [mfds_pkg::STATUS_W-1:0]    status_o
);
  import mfds_pkg::*;

  localparam int unsigned LIM_W  = $clog2(MaxFraction + 1);
  localparam int unsigned PROD_W = SRC_SW + LIM_W;
  localparam logic [DVD_W-1:0] DivMax = DVD_W'((64'd1 << DivideBits) - 64'd1);
  localparam int unsigned SCL_IN_W   = SRC_W - SCALE_PRE;
  localparam int unsigned SCL_PROD_W = SCL_IN_W + SCALE_RECIP_W;

  logic [SRC_W-1:0]  src_raw_q;
  logic [WANT_W-1:0] want_raw_q;
  logic [SRC_SW-1:0] src_q;
  logic [WANT_SW-1:0] want_q;
  logic [LIM_W-1:0]  limit_q;
  logic [LIM_W-1:0]  f_q;
  logic              have_q;
  logic              exact_q;
  logic [LIM_W-1:0]  best_f_q;
  logic [DVD_W-1:0]  best_d_q;
  logic [ERR_W-1:0]  best_e_q;

  logic [DIV_CODE_W-1:0]   out_div_q;
  logic [FRACT_CODE_W-1:0] out_fract_q;
  logic [ERR_W-1:0]        out_err_q;
  status_e                 out_stat_q;

  logic [SCL_IN_W-1:0]   scale_in;
  logic [SCL_PROD_W-1:0] scale_prod;
  logic [SRC_SW-1:0]     scaled;

  logic [DVD_W-1:0]  dividend;
  logic [DVS_W-1:0]  divisor;
  logic [PROD_W-1:0] prod;
  logic              div_busy, div_done;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;

  logic              cap_trial;
  logic [WANT_SW-1:0] rem_w;
  logic              round_up;
  logic [WANT_SW-1:0] err_full;
  logic [ERR_W-1:0]  err;
  logic [DVD_W-1:0]  d_trial;
  logic              take;
  logic [DVD_W-1:0]  best_dm1;

  // Scale to 100 Hz units: drop two bits, then multiply by the reciprocal of 25
  assign scale_in   = (cmd_i.div_sel == SEL_WANT) ? SCL_IN_W'(want_raw_q[WANT_W-1:SCALE_PRE])
                                                  : src_raw_q[SRC_W-1:SCALE_PRE];
  assign scale_prod = SCL_PROD_W'(scale_in) * SCL_PROD_W'(SCALE_RECIP);
  assign scaled     = scale_prod[SCALE_SHIFT +: SRC_SW];

  // One multiplier ahead of the divider's operand register
  assign prod = PROD_W'(src_q) * PROD_W'(f_q);

  always_comb begin
    dividend = '0;
    divisor  = '0;
    unique case (cmd_i.div_sel)
      SEL_LIMIT: begin
        dividend = {want_q, LIMIT_SHIFT'(0)};
        divisor  = src_q;
      end
      SEL_TRIAL: begin
        dividend = prod[DVD_W-1:0];
        divisor  = DVS_W'(want_q);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  mfds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // Trial evaluation: round to nearest, keep the first smallest error
  assign cap_trial = div_done && (cmd_i.div_sel == SEL_TRIAL);
  assign rem_w     = rem[WANT_SW-1:0];
  assign round_up  = rem_w > (want_q >> 1);
  assign err_full  = round_up ? (want_q - rem_w) : rem_w;
  assign err       = err_full[ERR_W-1:0];
  assign d_trial   = quo + DVD_W'(round_up);
  assign take      = (rem_w == '0) || !have_q || (err < best_e_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q     <= '0;
      have_q  <= 1'b0;
      exact_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      f_q     <= LIM_W'(1);
      have_q  <= 1'b0;
      exact_q <= 1'b0;
    end else if (cap_trial) begin
      f_q     <= f_q + LIM_W'(1);
      have_q  <= 1'b1;
      exact_q <= (rem_w == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      src_raw_q  <= src_hz_i;
      want_raw_q <= want_hz_i;
      src_q      <= '0;
      want_q     <= '0;
      limit_q    <= '0;
    end else if (cmd_i.scale) begin
      if (cmd_i.div_sel == SEL_WANT) begin
        want_q <= scaled[WANT_SW-1:0];
      end else begin
        src_q <= scaled;
      end
    end else if (div_done && (cmd_i.div_sel == SEL_LIMIT)) begin
      if (quo >= DVD_W'(MaxFraction - 1)) begin
        limit_q <= LIM_W'(MaxFraction);
      end else begin
        limit_q <= quo[LIM_W-1:0] + LIM_W'(1);
      end
    end
    if (cap_trial && take) begin
      best_f_q <= f_q;
      best_d_q <= d_trial;
      best_e_q <= err;
    end
  end

  // Result formatting
  assign best_dm1 = best_d_q - DVD_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (!have_q) begin
        out_div_q   <= '0;
        out_fract_q <= '0;
        out_err_q   <= '0;
        out_stat_q  <= STAT_NONE;
      end else begin
        out_fract_q <= FRACT_CODE_W'(best_f_q - LIM_W'(1));
        out_err_q   <= best_e_q;
        if (best_d_q == '0) begin
          out_div_q  <= '0;
          out_stat_q <= STAT_NONE;
        end else if (best_dm1 > DivMax) begin
          out_div_q  <= DivMax[DIV_CODE_W-1:0];
          out_stat_q <= STAT_SAT;
        end else begin
          out_div_q  <= best_dm1[DIV_CODE_W-1:0];
          out_stat_q <= STAT_OK;
        end
      end
    end
  end

  assign stat_o.div_busy   = div_busy;
  assign stat_o.div_done   = div_done;
  assign stat_o.zero_clk   = (src_q == '0) || (want_q == '0);
  assign stat_o.search_end = f_q >= limit_q;
  assign stat_o.exact      = exact_q;

  assign divide_code_o = out_div_q;
  assign fract_code_o  = out_fract_q;
  assign best_error_o  = out_err_q;
  assign status_o      = out_stat_q;

endmodule

// ===== rtl/mfds_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfds_ctrl: sequencer of the fractional divider search
// Steps the scaling, limit and trial divisions and owns the output valid.
// ----------------------------------------------------------------------------
module mfds_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mfds_pkg::cmd_t  cmd_o,
  input  mfds_pkg::stat_t stat_i
);
  import mfds_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        div_state;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_SCALE_SRC;
      ST_SCALE_SRC:  state_d = ST_SCALE_WANT;
      ST_SCALE_WANT: state_d = ST_CHECK;
      ST_CHECK:      state_d = stat_i.zero_clk ? ST_EMIT : ST_LIMIT;
      ST_LIMIT:      if (stat_i.div_done) state_d = ST_NEXT;
      ST_TRIAL:      if (stat_i.div_done) state_d = ST_NEXT;
      ST_NEXT: begin
        state_d = (stat_i.exact || stat_i.search_end) ? ST_EMIT : ST_TRIAL;
      end
      ST_EMIT:       if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_state      = 1'b0;
    cmd_o.scale    = 1'b0;
    cmd_o.div_sel  = SEL_SRC;
    unique case (state_q)
      ST_SCALE_SRC: begin
        cmd_o.scale   = 1'b1;
        cmd_o.div_sel = SEL_SRC;
      end
      ST_SCALE_WANT: begin
        cmd_o.scale   = 1'b1;
        cmd_o.div_sel = SEL_WANT;
      end
      ST_LIMIT: begin
        div_state     = 1'b1;
        cmd_o.div_sel = SEL_LIMIT;
      end
      ST_TRIAL: begin
        div_state     = 1'b1;
        cmd_o.div_sel = SEL_TRIAL;
      end
      default: begin
        div_state     = 1'b0;
        cmd_o.div_sel = SEL_SRC;
      end
    endcase
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    // Kick the divider once on entry to each division state
    cmd_o.div_start = div_state && !stat_i.div_busy && !stat_i.div_done;
    cmd_o.emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mclk_fractional_divider_search.sv =====
// ----------------------------------------------------------------------------
// mclk_fractional_divider_search: master-clock divide/fraction search
// Finds the divide and fraction pair that best turns a source clock into a
// wanted master clock, on a single shared serial divider.
// ----------------------------------------------------------------------------
// A request carries a source clock and a wanted master clock in Hz. Both are
// truncated to 100 Hz units, the fraction limit min(MaxFraction,
// want*4096/src + 1) is formed, and each fraction from 1 below that limit is
// tried: divide = src*f/want rounded to nearest, error = distance to the
// nearest multiple. An exact match stops the search; otherwise the first
// smallest error wins. The result gives divide-1 (saturated to DivideBits,
// status 2), fraction-1, the error, and status 1 when a scaled clock is zero,
// no fraction is tried, or the chosen divide is zero. The two scalings by 100
// share one reciprocal multiplier, one in each scaling state; the limit and
// trial divisions run on one 32-step restoring divider. One request is in
// work at a time; the next is taken while the previous result waits in the
// output register.
module mclk_fractional_divider_search #(
  parameter int unsigned MaxFraction = mfds_pkg::MAX_FRACTION_DEF,
  parameter int unsigned DivideBits  = mfds_pkg::DIVIDE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [29:0] source_clock_hz, [55:30] wanted_clock_hz
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [11:0] divide_code, [19:12] fract_code,
                                      // [38:20] best_error, [40:39] status, zero pad
);
  import mfds_pkg::*;

  localparam int unsigned OUT_USED = DIV_CODE_W + FRACT_CODE_W + ERR_W + STATUS_W;

  cmd_t  cmd;
  stat_t stat;

  logic [DIV_CODE_W-1:0]   divide_code;
  logic [FRACT_CODE_W-1:0] fract_code;
  logic [ERR_W-1:0]        best_error;
  logic [STATUS_W-1:0]     status;

  // Sequencer: owns the handshakes and steps the datapath
  mfds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath: operands, shared divider, best-pair tracking, result register
  mfds_dp #(
    .MaxFraction (MaxFraction),
    .DivideBits  (DivideBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .src_hz_i      (s_axis_tdata[SRC_W-1:0]),
    .want_hz_i     (s_axis_tdata[SRC_W+WANT_W-1:SRC_W]),
    .divide_code_o (divide_code),
    .fract_code_o  (fract_code),
    .best_error_o  (best_error),
    .status_o      (status)
  );

  // Pack result fields from the lowest bit up, zero pad to whole bytes
  assign m_axis_tdata = {(48 - OUT_USED)'(0), status, best_error, fract_code, divide_code};

  // A taken request leaves the idle state at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted but sequencer stayed idle");

  // The divider only finishes work that belongs to a request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !s_axis_tready)
    else $error("divider finished while sequencer idle");

  // Never restart the shared divider mid-division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // A loaded result shows up as valid in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid)
    else $error("result loaded but not presented");

endmodule
